// File: rtl/bre_pkg.sv
// Package for the bit run-length Elias encoder.
// Holds shared widths, the queue depth, the code kind type and the token control struct.
// No dependencies.
`default_nettype none

package bre_pkg;

    localparam int RUN_WIDTH_DEF = 32;
    localparam int CODE_W        = 64;
    localparam int LEN_W         = 6;
    localparam int QUEUE_DEPTH   = 4;

    typedef enum logic [0:0] {
        KIND_GAMMA = 1'b0,
        KIND_DELTA = 1'b1
    } t_code_kind;

    typedef struct packed {
        logic       raw;
        logic       fin;
        t_code_kind kind;
    } t_tok_ctl;

endpackage

`default_nettype wire

// File: rtl/bre_run_tracker.sv
// Run tracker: holds the code kind register and the run state, and turns
// each accepted bit into zero, one or two run tokens. Depends on bre_pkg.
`default_nettype none

module bre_run_tracker #(
    parameter int RUN_WIDTH = bre_pkg::RUN_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic                  i_cfg_wr_data,
    input  wire logic                  i_accept,
    input  wire logic                  i_src_bit,
    input  wire logic                  i_last_bit,
    output logic [1:0]                 o_push_cnt,
    output logic [RUN_WIDTH-1:0]       o_tok0_run,
    output bre_pkg::t_tok_ctl          o_tok0_ctl,
    output logic [RUN_WIDTH-1:0]       o_tok1_run,
    output bre_pkg::t_tok_ctl          o_tok1_ctl
);
    import bre_pkg::*;

    t_code_kind           r_kind;
    logic [RUN_WIDTH-1:0] r_count, n_count;
    logic                 r_pol, n_pol;
    logic                 r_started, n_started;

    logic                 w_first_tok;
    logic [RUN_WIDTH-1:0] w_first_run;
    logic                 w_first_raw;
    logic [RUN_WIDTH-1:0] w_mid_count;
    logic                 w_mid_pol;

    always_comb begin
        w_first_tok = 1'b0;
        w_first_run = r_count;
        w_first_raw = 1'b0;
        w_mid_count = r_count;
        w_mid_pol   = r_pol;
        if (!r_started) begin
            w_first_tok = 1'b1;
            w_first_raw = 1'b1;
            w_first_run = RUN_WIDTH'(i_src_bit);
            w_mid_count = RUN_WIDTH'(1);
            w_mid_pol   = i_src_bit;
        end else if (i_src_bit == r_pol) begin
            if (!(&r_count)) begin
                w_mid_count = r_count + RUN_WIDTH'(1);
            end
        end else begin
            w_first_tok = 1'b1;
            w_mid_count = RUN_WIDTH'(1);
            w_mid_pol   = ~r_pol;
        end

        o_tok0_run = w_first_tok ? w_first_run : w_mid_count;
        o_tok0_ctl = '{raw: w_first_tok & w_first_raw, fin: ~w_first_tok, kind: r_kind};
        o_tok1_run = w_mid_count;
        o_tok1_ctl = '{raw: 1'b0, fin: 1'b1, kind: r_kind};
        o_push_cnt = i_accept ? (2'(w_first_tok) + 2'(i_last_bit)) : 2'd0;

        n_count   = r_count;
        n_pol     = r_pol;
        n_started = r_started;
        if (i_accept) begin
            if (i_last_bit) begin
                n_count   = '0;
                n_pol     = 1'b0;
                n_started = 1'b0;
            end else begin
                n_count   = w_mid_count;
                n_pol     = w_mid_pol;
                n_started = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= KIND_GAMMA;
            r_count   <= '0;
            r_pol     <= 1'b0;
            r_started <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_kind <= t_code_kind'(i_cfg_wr_data);
            end
            r_count   <= n_count;
            r_pol     <= n_pol;
            r_started <= n_started;
        end
    end

endmodule

`default_nettype wire

// File: rtl/bre_tok_queue.sv
// Small token queue between the run tracker and the codeword former.
// Takes up to two tokens per cycle and releases at most one. Depends on bre_pkg.
`default_nettype none

module bre_tok_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [1:0]        i_push_cnt,
    input  wire logic [DATA_W-1:0] i_data0,
    input  wire logic [DATA_W-1:0] i_data1,
    input  wire logic              i_pop,
    output logic                   o_room,
    output logic                   o_head_valid,
    output logic [DATA_W-1:0]      o_head
);
    import bre_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PTR_W-1:0]  w_wr_next;

    always_comb begin
        w_wr_next    = r_wr + PTR_W'(1);
        o_room       = (r_cnt <= CNT_W'(QUEUE_DEPTH - 2));
        o_head_valid = (r_cnt != '0);
        o_head       = r_mem[r_rd];
        n_wr         = r_wr + PTR_W'(i_push_cnt);
        n_rd         = r_rd + PTR_W'(i_pop);
        n_cnt        = r_cnt + CNT_W'(i_push_cnt) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_data0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[w_wr_next] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// File: rtl/bre_code_former.sv
// Codeword former: turns the head token into a gamma, delta or raw codeword
// and holds it in the output register. Depends on bre_pkg.
`default_nettype none

module bre_code_former #(
    parameter int RUN_WIDTH = bre_pkg::RUN_WIDTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_head_valid,
    input  wire logic [RUN_WIDTH-1:0]      i_head_run,
    input  wire bre_pkg::t_tok_ctl         i_head_ctl,
    output logic                           o_pop,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [bre_pkg::CODE_W-1:0]     o_code_bits,
    output logic [bre_pkg::LEN_W-1:0]      o_code_len,
    output logic                           o_final_code
);
    import bre_pkg::*;

    localparam int LG_W = $clog2(RUN_WIDTH);
    localparam int M_W  = LG_W + 1;

    function automatic logic [LG_W-1:0] top_bit(input logic [RUN_WIDTH-1:0] v);
        logic [LG_W-1:0] p;
        p = '0;
        for (int i = 1; i < RUN_WIDTH; i++) begin
            if (v[i]) begin
                p = LG_W'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [LEN_W-1:0] top_bit_m(input logic [M_W-1:0] v);
        logic [LEN_W-1:0] p;
        p = '0;
        for (int i = 1; i < M_W; i++) begin
            if (v[i]) begin
                p = LEN_W'(i);
            end
        end
        return p;
    endfunction

    logic                r_valid;
    logic [CODE_W-1:0]   r_bits, n_bits;
    logic [LEN_W-1:0]    r_len, n_len;
    logic                r_fin;

    logic [LG_W-1:0]     w_lg;
    logic [M_W-1:0]      w_m;
    logic [LEN_W-1:0]    w_mg;
    logic [CODE_W-1:0]   w_mask;

    always_comb begin
        o_pop  = i_head_valid && (!r_valid || i_ready);
        w_lg   = top_bit(i_head_run);
        w_m    = M_W'(w_lg) + M_W'(1);
        w_mg   = top_bit_m(w_m);
        w_mask = ~({CODE_W{1'b1}} << w_lg);

        if (i_head_ctl.raw) begin
            n_bits = CODE_W'(i_head_run[0]);
            n_len  = LEN_W'(1);
        end else begin
            unique case (i_head_ctl.kind)
                KIND_GAMMA: begin
                    n_bits = CODE_W'(i_head_run);
                    n_len  = LEN_W'({w_lg, 1'b1});
                end
                KIND_DELTA: begin
                    n_bits = (CODE_W'(w_m) << w_lg) | (CODE_W'(i_head_run) & w_mask);
                    n_len  = LEN_W'({w_mg, 1'b1}) + LEN_W'(w_lg);
                end
                default: begin
                    n_bits = CODE_W'(i_head_run);
                    n_len  = LEN_W'({w_lg, 1'b1});
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bits <= n_bits;
            r_len  <= n_len;
            r_fin  <= i_head_ctl.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid      = r_valid;
    assign o_code_bits  = r_bits;
    assign o_code_len   = r_len;
    assign o_final_code = r_fin;

endmodule

`default_nettype wire

// File: rtl/bit_run_length_elias_encoder.sv
// Top level of the bit run-length Elias encoder.
// Instantiates bre_run_tracker, bre_tok_queue and bre_code_former; uses bre_pkg.
//
// Usage:
// The input channel (i_valid, o_ready) takes one source bit per transfer,
// most significant bit first, with i_last_bit on the final bit of a vector.
// The output channel (o_valid, i_ready) returns right-aligned codewords with
// their length; o_final_code marks the last codeword of a vector.
// The first bit of a vector comes out raw as a one-bit codeword; each run
// after that comes out as one Elias gamma or delta codeword, as chosen by
// the one-bit register written through i_cfg_wr_en and i_cfg_wr_data.
// An input bit's first codeword passes through the token queue and then the output register.
// One input bit is taken every cycle while the output is drained; a bit
// that yields two codewords needs two output transfers, and the four-entry
// token queue absorbs that, so o_ready drops only while fewer than two of
// its entries are free.
// When the receiver stalls the output register holds its codeword and the
// queue fills, after which o_ready falls. Reset clears the run state, the
// queue and the output valid flag and selects gamma codes.
`default_nettype none

module bit_run_length_elias_encoder #(
    parameter int RUN_WIDTH = bre_pkg::RUN_WIDTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic                      i_cfg_wr_data,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_src_bit,
    input  wire logic                      i_last_bit,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [bre_pkg::CODE_W-1:0]     o_code_bits,
    output logic [bre_pkg::LEN_W-1:0]      o_code_len,
    output logic                           o_final_code
);
    import bre_pkg::*;

    localparam int CTL_W  = $bits(t_tok_ctl);
    localparam int DATA_W = RUN_WIDTH + CTL_W;

    logic                 w_accept;
    logic [1:0]           w_push_cnt;
    logic [RUN_WIDTH-1:0] w_tok0_run, w_tok1_run;
    t_tok_ctl             w_tok0_ctl, w_tok1_ctl;
    logic                 w_room;
    logic                 w_head_valid;
    logic [DATA_W-1:0]    w_head;
    logic                 w_pop;

    assign o_ready  = w_room;
    assign w_accept = i_valid && w_room;

    bre_run_tracker #(
        .RUN_WIDTH(RUN_WIDTH)
    ) u_tracker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (w_accept),
        .i_src_bit     (i_src_bit),
        .i_last_bit    (i_last_bit),
        .o_push_cnt    (w_push_cnt),
        .o_tok0_run    (w_tok0_run),
        .o_tok0_ctl    (w_tok0_ctl),
        .o_tok1_run    (w_tok1_run),
        .o_tok1_ctl    (w_tok1_ctl)
    );

    bre_tok_queue #(
        .DATA_W(DATA_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_cnt   (w_push_cnt),
        .i_data0      ({w_tok0_ctl, w_tok0_run}),
        .i_data1      ({w_tok1_ctl, w_tok1_run}),
        .i_pop        (w_pop),
        .o_room       (w_room),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    bre_code_former #(
        .RUN_WIDTH(RUN_WIDTH)
    ) u_former (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head_run   (w_head[RUN_WIDTH-1:0]),
        .i_head_ctl   (t_tok_ctl'(w_head[DATA_W-1:RUN_WIDTH])),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_code_bits  (o_code_bits),
        .o_code_len   (o_code_len),
        .o_final_code (o_final_code)
    );

endmodule

`default_nettype wire

// File: rtl/bre_checker.sv
// Port-level checker for the bit run-length Elias encoder, bound to the top.
// Depends on bre_pkg and on the top level's port names.
`default_nettype none

module bre_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_valid,
    input wire logic                      i_ready,
    input wire logic [bre_pkg::CODE_W-1:0] o_code_bits,
    input wire logic [bre_pkg::LEN_W-1:0]  o_code_len,
    input wire logic                      o_final_code
);
    import bre_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_code_bits)
            && $stable(o_code_len) && $stable(o_final_code))
        else $error("stalled codeword changed");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_code_len != '0)
        else $error("codeword with zero length");

    a_one_bit_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_code_len == LEN_W'(1) |-> o_code_bits[CODE_W-1:1] == '0)
        else $error("one-bit codeword has stray upper bits");

endmodule

bind bit_run_length_elias_encoder bre_checker u_bre_checker (.*);

`default_nettype wire
